// ===== design/oaht_pkg.sv =====
// Package: shared constants and types of the string hash table.
`default_nettype none
package oaht_pkg;
	localparam int SLOTS_DEF = 4096;
	localparam int KEY_CHARS_DEF = 19;
	localparam logic [31:0] MUL_A = 32'd2654289789;
	localparam logic [12:0] SIZE_RESET = 13'd4096;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_TOO_LONG = 3'd5;

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_HASH_MODE = 1'b1;

	typedef struct packed {
		logic take_char;   // append in_char to pending key
		logic start_hash;  // begin home slot computation
		logic hash_step;   // advance home slot unit
		logic probe_init;  // load probe slot from home
		logic rd_meta;     // read used/length of probe slot
		logic rd_char;     // read one stored char at char counter
		logic char_next;   // advance char counter
		logic probe_next;  // advance to next slot
		logic write_meta;  // claim slot
		logic write_char;  // store char at char counter
		logic coll_inc;
		logic coll_back;
		logic found_inc;
		logic clear_key;
	} oaht_cmd_t;

	typedef struct packed {
		logic hash_done;
		logic too_long;
		logic used;       // probe slot used
		logic len_eq;     // stored length equals pending
		logic char_eq;    // stored char equals pending
		logic char_last;  // char counter at last char
		logic probe_last; // all slots probed
	} oaht_stat_t;
endpackage
`default_nettype wire

// ===== design/oaht_if.sv =====
// Interfaces: valid/ready word channels of the hash table.
`default_nettype none
interface oaht_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] key_char;
	logic       last_char;
	modport source(output valid, func, key_char, last_char, input ready);
	modport sink(input valid, func, key_char, last_char, output ready);
endinterface

interface oaht_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] slot_index;
	logic [31:0] collision_count;
	logic [31:0] found_count;
	modport source(output valid, status, slot_index, collision_count, found_count, input ready);
	modport sink(input valid, status, slot_index, collision_count, found_count, output ready);
endinterface
`default_nettype wire

// ===== design/oaht_datapath.sv =====
// Datapath: pending key, hash unit, slot memories, probe and counters.
`default_nettype none
module oaht_datapath
	import oaht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int KEY_CHARS = KEY_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  in_char,
	input  wire logic [12:0] table_size,
	input  wire logic        hash_mode,
	input  wire oaht_cmd_t   cmd,
	output oaht_stat_t       stat,
	output logic [11:0]      slot_out,
	output logic [31:0]      coll_out,
	output logic [31:0]      found_out
);
	localparam int SW = $clog2(SLOTS);
	localparam int BW = SW + 1;
	localparam int LW = $clog2(KEY_CHARS + 2);
	localparam int CW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
	localparam int AW = $clog2(SLOTS * KEY_CHARS);
	localparam int HB = 6; // step count that ends the multiplicative product

	logic [7:0]    pend_q [KEY_CHARS];
	logic [LW-1:0] plen_q;
	logic [31:0]   fold_q;
	logic [31:0]   coll_q, found_q;
	logic [BW-1:0] b_q;
	logic [SW-1:0] home_q, slot_q;
	logic [BW-1:0] probes_q;
	logic [CW-1:0] cidx_q;
	logic          used_q;
	logic [LW-1:0] len_q;
	logic [7:0]    chr_q;
	logic          used_mem [SLOTS];
	logic          clr_busy_q;
	logic [SW-1:0] clr_q;
	logic [LW-1:0] len_mem [SLOTS];
	logic [7:0]    chr_mem [SLOTS*KEY_CHARS];

	// hash unit: restoring remainder or partial product multiply
	logic [31:0]   rem_q;
	logic [5:0]    hcnt_q;
	logic          hmode_q;
	logic [63:0]   acc_q;
	logic [31:0]   frac_q;
	logic [BW-1:0] b_eff;
	logic [32:0]   trial;
	logic [AW-1:0] caddr;
	logic [31:0]   mul_a;
	logic          hash_end;

	always_comb begin
		b_eff = table_size[BW-1:0];
		if (table_size == 13'd0) b_eff = BW'(1);
		else if (32'(table_size) > 32'(SLOTS)) b_eff = BW'(SLOTS);
	end

	assign trial = {rem_q, fold_q[31 - hcnt_q[4:0]]} - {{(33-BW){1'b0}}, b_q};
	assign caddr = AW'(32'(slot_q) * 32'(KEY_CHARS) + 32'(cidx_q));
	assign mul_a = MUL_A;
	assign hash_end = hmode_q ? (hcnt_q == 6'd32) : (hcnt_q == 6'(HB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			fold_q <= '0;
			coll_q <= '0;
			found_q <= '0;
			hcnt_q <= '0;
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				used_mem[clr_q] <= 1'b0;
				clr_q <= clr_q + SW'(1);
				if (32'(clr_q) == 32'(SLOTS - 1)) clr_busy_q <= 1'b0;
			end
			if (cmd.take_char) begin
				fold_q <= {fold_q[23:0], in_char};
				if (32'(plen_q) < 32'(KEY_CHARS)) pend_q[CW'(plen_q)] <= in_char;
				if (32'(plen_q) <= 32'(KEY_CHARS)) plen_q <= plen_q + LW'(1);
			end
			if (cmd.clear_key) begin
				plen_q <= '0;
				fold_q <= '0;
			end
			if (cmd.start_hash) begin
				b_q <= b_eff;
				hmode_q <= hash_mode;
				rem_q <= '0;
				hcnt_q <= '0;
				acc_q <= '0;
			end else if (cmd.hash_step && !hash_end) begin
				hcnt_q <= hcnt_q + 6'd1;
				if (hmode_q) begin
					rem_q <= trial[32] ? {rem_q[30:0], fold_q[31 - hcnt_q[4:0]]} : trial[31:0];
				end else if (hcnt_q < 6'd4) begin
					// 32x8 partial products of x*A, low word kept
					acc_q <= acc_q + ({32'd0, fold_q * 32'(mul_a[hcnt_q[1:0]*8 +: 8])}
						<< (hcnt_q[1:0] * 8));
				end else if (hcnt_q == 6'd4) begin
					frac_q <= acc_q[31:0];
				end else begin
					acc_q <= 64'(frac_q) * 64'(b_q);
				end
			end
			if (cmd.probe_init) begin
				slot_q <= home_q;
				probes_q <= BW'(1);
				cidx_q <= '0;
			end
			if (cmd.probe_next) begin
				slot_q <= (32'(slot_q) + 1 == 32'(b_q)) ? '0 : slot_q + SW'(1);
				probes_q <= probes_q + BW'(1);
				cidx_q <= '0;
			end
			if (cmd.char_next) cidx_q <= cidx_q + CW'(1);
			if (cmd.write_meta) used_mem[slot_q] <= 1'b1;
			if (cmd.coll_inc) coll_q <= coll_q + 32'd1;
			if (cmd.coll_back) coll_q <= coll_q - 32'(probes_q - BW'(1));
			if (cmd.found_inc) found_q <= found_q + 32'd1;
		end
	end

	always_comb begin
		home_q = hmode_q ? rem_q[SW-1:0] : acc_q[32 +: SW];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_meta) begin
			used_q <= used_mem[slot_q];
			len_q <= len_mem[slot_q];
		end
		if (cmd.write_meta) len_mem[slot_q] <= plen_q;
		if (cmd.rd_char) chr_q <= chr_mem[caddr];
		if (cmd.write_char) chr_mem[caddr] <= pend_q[cidx_q];
	end

	always_comb begin
		stat.hash_done = !clr_busy_q && hash_end;
		stat.too_long = 32'(plen_q) > 32'(KEY_CHARS);
		stat.used = used_q;
		stat.len_eq = len_q == plen_q;
		stat.char_eq = chr_q == pend_q[cidx_q];
		stat.char_last = 32'(cidx_q) + 1 >= 32'(plen_q);
		stat.probe_last = probes_q == b_q;
	end

	assign slot_out = 12'(slot_q);
	assign coll_out = coll_q;
	assign found_out = found_q;
endmodule
`default_nettype wire

// ===== design/oaht_ctrl.sv =====
// Controller: sequences hashing, probing, key compare and result.
`default_nettype none
module oaht_ctrl
	import oaht_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	oaht_in_if.sink    in_ch,
	oaht_out_if.source out_ch,
	input  oaht_stat_t stat,
	input  wire logic [11:0] slot_dp,
	input  wire logic [31:0] coll_dp,
	input  wire logic [31:0] found_dp,
	output oaht_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_PROBE, S_META, S_CMP_RD, S_CMP, S_WRITE, S_RES, S_OUT
	} state_t;

	state_t     state_q;
	logic       func_q;
	logic [2:0] st_q;
	logic       slot_z_q;

	assign in_ch.ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.take_char = in_ch.valid && in_ch.ready;
		cmd.start_hash = in_ch.valid && in_ch.ready && in_ch.last_char;
		case (state_q)
			S_HASH: begin
				cmd.hash_step = !stat.hash_done;
				cmd.probe_init = stat.hash_done;
			end
			S_PROBE: cmd.rd_meta = 1'b1;
			S_META: begin
				if (stat.used && stat.len_eq) cmd.rd_char = 1'b1;
				else if (stat.used) begin
					cmd.coll_inc = !func_q;
					cmd.probe_next = !stat.probe_last;
				end
			end
			S_CMP: begin
				if (stat.char_eq && !stat.char_last) cmd.char_next = 1'b1;
				else if (stat.char_eq) begin
					cmd.coll_back = !func_q;
					cmd.found_inc = func_q;
				end else begin
					cmd.coll_inc = !func_q;
					cmd.probe_next = !stat.probe_last;
				end
			end
			S_CMP_RD: cmd.rd_char = 1'b1;
			S_WRITE: begin
				cmd.write_char = 1'b1;
				cmd.char_next = !stat.char_last;
				cmd.write_meta = stat.char_last;
			end
			S_RES: cmd.clear_key = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_ch.valid <= 1'b0;
			func_q <= 1'b0;
			st_q <= ST_NOT_FOUND;
			slot_z_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.last_char) begin
					func_q <= in_ch.func;
					state_q <= S_HASH;
				end
				S_HASH: if (stat.hash_done) begin
					if (stat.too_long) begin
						st_q <= ST_TOO_LONG;
						slot_z_q <= 1'b1;
						state_q <= S_RES;
					end else state_q <= S_PROBE;
				end
				S_PROBE: state_q <= S_META;
				S_META: begin
					if (!stat.used) begin
						st_q <= func_q ? ST_NOT_FOUND : ST_INSERTED;
						slot_z_q <= func_q;
						state_q <= func_q ? S_RES : S_WRITE;
					end else if (stat.len_eq) state_q <= S_CMP;
					else if (stat.probe_last) begin
						st_q <= func_q ? ST_NOT_FOUND : ST_FULL;
						slot_z_q <= 1'b1;
						state_q <= S_RES;
					end else state_q <= S_PROBE;
				end
				S_CMP: begin
					if (stat.char_eq && !stat.char_last) state_q <= S_CMP_RD;
					else if (stat.char_eq) begin
						st_q <= func_q ? ST_FOUND : ST_PRESENT;
						slot_z_q <= 1'b0;
						state_q <= S_RES;
					end else if (stat.probe_last) begin
						st_q <= func_q ? ST_NOT_FOUND : ST_FULL;
						slot_z_q <= 1'b1;
						state_q <= S_RES;
					end else state_q <= S_PROBE;
				end
				S_CMP_RD: state_q <= S_CMP;
				S_WRITE: if (stat.char_last) state_q <= S_RES;
				S_RES: begin
					out_ch.status <= st_q;
					out_ch.slot_index <= slot_z_q ? 12'd0 : slot_dp;
					out_ch.collision_count <= coll_dp;
					out_ch.found_count <= found_dp;
					out_ch.valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input taken with result pending");
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status == ST_FULL || out_ch.status == ST_NOT_FOUND)
		|-> out_ch.slot_index == 12'd0)
		else $error("nonzero slot on miss");
endmodule
`default_nettype wire

// ===== design/open_addressing_string_hash_table.sv =====
// Top level: string hash table with linear probing.
//  channel | dir | word
//  in_ch   | in  | func, key_char, last_char
//  out_ch  | out | status, slot_index, collision_count, found_count
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// Non-final chars are taken while idle. A key end runs the remainder (division)
// or multiply hash, then a meta read per probe and a read and compare per
// compared byte, a write per stored byte on insert, then posts the result.
// After reset a clearing pass sweeps the used bits of all SLOTS first.
// A stalled result holds the block; no new char is taken until it is delivered.
`default_nettype none
module open_addressing_string_hash_table
	import oaht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int KEY_CHARS = KEY_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	oaht_in_if.sink          in_ch,
	oaht_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);
	logic [12:0] size_q;
	logic        mode_q;
	oaht_cmd_t   cmd;
	oaht_stat_t  stat;
	logic [11:0] slot;
	logic [31:0] coll, found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TABLE_SIZE: size_q <= cfg_data;
				CFG_HASH_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	oaht_datapath #(.SLOTS(SLOTS), .KEY_CHARS(KEY_CHARS)) u_dp (
		.clk, .arst_n, .in_char(in_ch.key_char), .table_size(size_q),
		.hash_mode(mode_q), .cmd, .stat, .slot_out(slot), .coll_out(coll),
		.found_out(found)
	);

	oaht_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch, .stat, .slot_dp(slot), .coll_dp(coll),
		.found_dp(found), .cmd
	);
endmodule
`default_nettype wire
